@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// shared types and codes for the sorted priority queue
// no dependencies

package spq_pkg;

  typedef enum logic [1:0] {
    FUNC_ENQUEUE = 2'd0,
    FUNC_DEQUEUE = 2'd1,
    FUNC_PEEK    = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned ReqPrioW = 16;
  localparam int unsigned TotalW = 5;

  typedef struct packed {
    func_e                      func;
    logic signed [ValueW-1:0]   item_value;
    logic signed [ReqPrioW-1:0] item_priority;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] head_value;
    logic [TotalW-1:0]        entry_total;
    logic                     is_empty;
  } rsp_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_cmd_t;

endpackage

@@ rtl/spq_cell.sv @@
`timescale 1ns / 1ps
// one slot of the sorted cell row: holds a value/priority pair
// depends on spq_pkg

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PRIO_BITS = 16
) (
  input  logic                       clk_i,
  input  cell_cmd_t                  cmd_i,
  input  logic signed [ValueW-1:0]   new_value_i,
  input  logic signed [PRIO_BITS-1:0] new_prio_i,
  input  logic                       occupied_i,
  input  logic                       left_ins_i,
  input  logic signed [ValueW-1:0]   left_value_i,
  input  logic signed [PRIO_BITS-1:0] left_prio_i,
  input  logic signed [ValueW-1:0]   right_value_i,
  input  logic signed [PRIO_BITS-1:0] right_prio_i,
  output logic                       ins_o,
  output logic signed [ValueW-1:0]   value_o,
  output logic signed [PRIO_BITS-1:0] prio_o
);

  logic signed [ValueW-1:0]    value_q, value_d;
  logic signed [PRIO_BITS-1:0] prio_q, prio_d;

  // new entry belongs at or before this slot
  assign ins_o = !occupied_i || (prio_q < new_prio_i);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (cmd_i.enq && ins_o) begin
      if (left_ins_i) begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end else begin
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end
    end else if (cmd_i.deq) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

@@ rtl/sorted_priority_queue_core.sv @@
`timescale 1ns / 1ps
// top level of the sorted priority queue: cell row, count and response register
// depends on spq_pkg and spq_cell

// Bounded priority queue holding up to DEPTH value/priority pairs in a row of
// cells kept sorted with the highest signed priority at cell 0; equal
// priorities leave in arrival order. Each request is enqueue, dequeue head,
// peek head or clear, and gives exactly one response with a status, the head
// value (0 where none applies), the entry count after the request and an
// empty flag. Every cell compares its priority with the incoming one in
// parallel and the whole row shifts right (insert) or left (dequeue) at the
// same clock edge, so one request is taken per cycle while the response
// register is free or being drained in the same cycle. The response sits in
// that output register from the cycle after acceptance. Enqueue on a full
// queue is refused with a full status and changes nothing; dequeue or peek
// on an empty queue reports empty. Slot contents are not reset; only slots
// below the entry count are ever read.

module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned PRIO_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // entry count and response register
  logic [CntW-1:0] count_q, count_d;
  logic            rsp_valid_q;
  rsp_t            rsp_q, rsp_d;

  logic accept;
  logic full;
  logic empty;

  // incoming priority, sign-extended then cut to the stored width
  logic signed [31:0]           prio_ext;
  logic signed [PRIO_BITS-1:0]  new_prio;
  cell_cmd_t                    cmd;

  // chain taps between neighbouring cells
  logic                        ins   [DEPTH];
  logic signed [ValueW-1:0]    value [DEPTH];
  logic signed [PRIO_BITS-1:0] prio  [DEPTH];

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  // response register frees up when drained in the same cycle
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  assign prio_ext = 32'(req_i.item_priority);
  assign new_prio = prio_ext[PRIO_BITS-1:0];

  assign cmd.enq = accept && (req_i.func == FUNC_ENQUEUE) && !full;
  assign cmd.deq = accept && (req_i.func == FUNC_DEQUEUE) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                        left_ins;
    logic signed [ValueW-1:0]    left_value;
    logic signed [PRIO_BITS-1:0] left_prio;
    logic signed [ValueW-1:0]    right_value;
    logic signed [PRIO_BITS-1:0] right_prio;

    if (i == 0) begin : g_first
      // head cell has no left neighbour: on insert it takes the new entry
      assign left_ins   = 1'b0;
      assign left_value = '0;
      assign left_prio  = '0;
    end else begin : g_mid
      assign left_ins   = ins[i-1];
      assign left_value = value[i-1];
      assign left_prio  = prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      // tail cell keeps its contents on dequeue; it falls outside the count
      assign right_value = value[i];
      assign right_prio  = prio[i];
    end else begin : g_inner
      assign right_value = value[i+1];
      assign right_prio  = prio[i+1];
    end

    spq_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .new_value_i  (req_i.item_value),
      .new_prio_i   (new_prio),
      .occupied_i   (count_q > CntW'(i)),
      .left_ins_i   (left_ins),
      .left_value_i (left_value),
      .left_prio_i  (left_prio),
      .right_value_i(right_value),
      .right_prio_i (right_prio),
      .ins_o        (ins[i]),
      .value_o      (value[i]),
      .prio_o       (prio[i])
    );
  end

  // count update and response word
  always_comb begin
    logic [31:0] total_ext;
    count_d          = count_q;
    rsp_d            = rsp_q;
    if (accept) begin
      rsp_d.status     = STATUS_OK;
      rsp_d.head_value = '0;
      case (req_i.func)
        FUNC_ENQUEUE: begin
          if (full) begin
            rsp_d.status = STATUS_FULL;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        FUNC_DEQUEUE: begin
          if (empty) begin
            rsp_d.status = STATUS_EMPTY;
          end else begin
            rsp_d.head_value = value[0];
            count_d          = count_q - CntW'(1);
          end
        end
        FUNC_PEEK: begin
          if (empty) begin
            rsp_d.status = STATUS_EMPTY;
          end else begin
            rsp_d.head_value = value[0];
          end
        end
        default: begin
          // clear: cell contents become unreachable once the count drops
          count_d = '0;
        end
      endcase
    end
    total_ext         = 32'(count_d);
    if (accept) begin
      rsp_d.entry_total = total_ext[TotalW-1:0];
      rsp_d.is_empty    = (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for sorted_priority_queue_core: queue-fed request driver,
// response monitor against a sorted-list predictor, random idling and a watchdog
// depends on spq_pkg and the core rtl

module tb_top;
  import spq_pkg::*;

  localparam int Depth     = 16;
  localparam int PrioBits  = 16;
  localparam int WatchMax  = 2000;
  localparam int HoldLen   = 120;
  localparam int PrintCap  = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic req_valid = 1'b0;
  logic req_ready_o;
  req_t req_payload = '0;
  logic rsp_valid_o;
  logic rsp_ready = 1'b0;
  rsp_t rsp_o;

  sorted_priority_queue_core #(
    .DEPTH    (Depth),
    .PRIO_BITS(PrioBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready_o),
    .req_i      (req_payload),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // requests waiting to be offered, responses waiting to arrive
  req_t req_backlog[$];
  rsp_t expected_rsp[$];

  int send_idle = 36;
  int recv_idle = 74;
  bit hold_req = 1'b0;
  int mismatches = 0;

  // predictor state: slots sorted by priority, highest first
  logic signed [ValueW-1:0]   slot_val  [Depth];
  logic signed [PrioBits-1:0] slot_prio [Depth];
  int                         slot_fill = 0;

  function automatic rsp_t queue_apply(input req_t r);
    rsp_t                       o;
    logic signed [PrioBits-1:0] p;
    int                         pos;
    o.status     = STATUS_OK;
    o.head_value = '0;
    p = r.item_priority[PrioBits-1:0];
    case (r.func)
      FUNC_ENQUEUE: begin
        if (slot_fill >= Depth) begin
          o.status = STATUS_FULL;
        end else begin
          // behind every entry of equal or higher priority
          pos = slot_fill;
          for (int i = slot_fill - 1; i >= 0; i--) begin
            if (slot_prio[i] < p) pos = i;
          end
          for (int i = slot_fill; i > pos; i--) begin
            slot_val[i]  = slot_val[i-1];
            slot_prio[i] = slot_prio[i-1];
          end
          slot_val[pos]  = r.item_value;
          slot_prio[pos] = p;
          slot_fill++;
        end
      end
      FUNC_DEQUEUE: begin
        if (slot_fill == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.head_value = slot_val[0];
          for (int i = 1; i < slot_fill; i++) begin
            slot_val[i-1]  = slot_val[i];
            slot_prio[i-1] = slot_prio[i];
          end
          slot_fill--;
        end
      end
      FUNC_PEEK: begin
        if (slot_fill == 0) o.status = STATUS_EMPTY;
        else o.head_value = slot_val[0];
      end
      default: begin
        slot_fill = 0;
      end
    endcase
    o.entry_total = TotalW'(slot_fill);
    o.is_empty    = (slot_fill == 0);
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PrintCap) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic push_req(input func_e f, input logic [ValueW-1:0] v,
                          input logic [ReqPrioW-1:0] p);
    req_t r;
    r.func          = f;
    r.item_value    = v;
    r.item_priority = p;
    req_backlog.push_back(r);
  endtask

  // bursts that lean towards filling or draining, so full and empty are both hit
  task automatic push_random(input int n);
    req_t r;
    int   pick;
    int   burst;
    int   t;
    bit   filling;
    burst   = 0;
    filling = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        filling = 1'($urandom_range(0, 1));
        burst   = $urandom_range(4, 28);
      end
      burst--;
      r.item_value = $urandom();
      t = $urandom_range(0, 9);
      case (t)
        0: r.item_priority = {1'b0, {(ReqPrioW-1){1'b1}}};
        1: r.item_priority = {1'b1, {(ReqPrioW-1){1'b0}}};
        2, 3: r.item_priority = ReqPrioW'($urandom());
        default: r.item_priority = ReqPrioW'($urandom_range(0, 6) - 3);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 3) r.func = FUNC_CLEAR;
      else if (pick < 18) r.func = FUNC_PEEK;
      else if (pick < 84) r.func = filling ? FUNC_ENQUEUE : FUNC_DEQUEUE;
      else r.func = filling ? FUNC_DEQUEUE : FUNC_ENQUEUE;
      req_backlog.push_back(r);
    end
  endtask

  // request driver: predicts on acceptance, then offers the next backlog entry
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready_o) expected_rsp.push_back(queue_apply(req_payload));
      if (!req_valid || req_ready_o) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          req_valid   <= 1'b1;
          req_payload <= req_backlog.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response side ready, with one long hold-off to back the core up
  int hold_left = 0;
  bit hold_taken = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : rsp_receiver
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HoldLen;
      rsp_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin : rsp_monitor
    rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("response with nothing outstanding");
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_o.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp_o.status, want.status));
        if (rsp_o.head_value !== want.head_value)
          report_mismatch($sformatf("head_value %0d, want %0d",
                                    rsp_o.head_value, want.head_value));
        if (rsp_o.entry_total !== want.entry_total)
          report_mismatch($sformatf("entry_total %0d, want %0d",
                                    rsp_o.entry_total, want.entry_total));
        if (rsp_o.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty %0b, want %0b", rsp_o.is_empty, want.is_empty));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  int quiet_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((req_valid && req_ready_o) || (rsp_valid_o && rsp_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchMax) begin
        $display("watchdog: no handshake for %0d cycles", WatchMax);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_valid || expected_rsp.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty cases, priority extremes, ties, full, clear
    push_req(FUNC_PEEK, $urandom(), ReqPrioW'($urandom()));
    push_req(FUNC_DEQUEUE, $urandom(), ReqPrioW'($urandom()));
    push_req(FUNC_ENQUEUE, 32'h7FFF_FFFF, 16'h7FFF);
    push_req(FUNC_ENQUEUE, 32'h8000_0000, 16'h8000);
    push_req(FUNC_ENQUEUE, 32'h0000_0001, 16'h0000);
    push_req(FUNC_ENQUEUE, 32'h0000_0002, 16'h0000);
    push_req(FUNC_ENQUEUE, 32'hFFFF_FFFF, 16'h7FFF);
    for (int k = 0; k < 11; k++) push_req(FUNC_ENQUEUE, $urandom(), ReqPrioW'(k - 5));
    push_req(FUNC_ENQUEUE, 32'h0000_0000, 16'h7FFF);
    push_req(FUNC_PEEK, 32'h0, 16'h0);
    push_req(FUNC_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
    push_req(FUNC_DEQUEUE, 32'h0, 16'h0);
    push_req(FUNC_CLEAR, $urandom(), ReqPrioW'($urandom()));
    push_req(FUNC_PEEK, 32'h0, 16'h0);
    push_req(FUNC_DEQUEUE, 32'h0, 16'h0);
    wait_drained();

    // slow sender, slower receiver
    push_random(290);
    wait_drained();

    // roles swapped
    send_idle = 74;
    recv_idle = 36;
    push_random(290);
    wait_drained();

    // full rate, with one long receiver hold-off at the start
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    push_random(290);
    wait_drained();

    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
